// ===== rtl/manchester_hdlc_edge_frame_decoder_unit_macros.svh =====
// assertion macros for the manchester / hdlc edge frame decoder
// no dependencies; taken in by the files that assert
`ifndef MANCHESTER_HDLC_EDGE_FRAME_DECODER_UNIT_MACROS_SVH
`define MANCHESTER_HDLC_EDGE_FRAME_DECODER_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define MHFD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in any cycle implies consequent in the next
`define MHFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mhfd_pkg.sv =====
// shared types and codes of the manchester / hdlc edge frame decoder
// no dependencies
package mhfd_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_FEW_EDGES = 2'd1;
	localparam status_t ST_NO_SYNC   = 2'd2;
	localparam status_t ST_VIOLATION = 2'd3;

	// frame close from the decoder to the field extractor
	typedef struct packed {
		logic    valid;
		status_t status;
	} frame_end_t;

	// field selection registers used by the extractor
	typedef struct packed {
		logic [7:0] pos_offset;
		logic [5:0] pos_length;
		logic [7:0] aux_offset;
		logic [5:0] aux_length;
		logic [7:0] flag0_index;
		logic [7:0] flag1_index;
		logic [7:0] flag2_index;
	} field_cfg_t;

	// finished result from the extractor
	typedef struct packed {
		logic        valid;
		logic [31:0] position;
		logic [31:0] aux_field;
		logic [2:0]  flags;
		logic [8:0]  bits_received;
		status_t     status;
	} xresult_t;

endpackage

// ===== rtl/mhfd_ram.sv =====
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module mhfd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/mhfd_decoder.sv =====
// edge interval classing, sync search, manchester decode and hdlc unstuffing
// depends on mhfd_pkg; writes decoded bits into the bit store ram
module mhfd_decoder import mhfd_pkg::*; #(
	parameter int DEPTH     = 256,
	parameter int MAX_EDGES = 512,
	parameter int MIN_EDGES = 80
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [15:0]                capture_time,
	input  logic                       last,
	input  logic [15:0]                short_interval,
	output logic                       wr_en,
	output logic [$clog2(DEPTH)-1:0]   wr_addr,
	output logic                       wr_data,
	output frame_end_t                 frame_end,
	output logic [$clog2(DEPTH+1)-1:0] bit_count
);

	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int BW  = $clog2(DEPTH + 1);
	localparam int AW  = $clog2(DEPTH);

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_DECODE = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [3:0] SYNC_SHORTS = 4'd10;
	localparam logic [3:0] STUFF_RUN   = 4'd5;
	localparam logic [3:0] FLAG_RUN    = 4'd6;
	localparam logic [3:0] RUN_MAX     = 4'd15;

	logic [15:0]    prev_time_q, prev_time_n;
	logic [ECW-1:0] edge_cnt_q, edge_cnt_n;
	logic [1:0]     phase_q, phase_n;
	logic [3:0]     run_q, run_n;
	logic           pol_q, pol_n;
	logic           pend_q, pend_n;
	logic [BW-1:0]  bit_idx_q, bit_idx_n;
	status_t        fstat_q, fstat_n;

	logic [15:0] delta;
	logic        is_short;
	logic        emit;
	logic        emit_bit;
	status_t     close_status;

	assign delta    = capture_time - prev_time_q;
	assign is_short = delta < short_interval;

	// next frame state for one accepted edge
	always_comb begin
		prev_time_n = prev_time_q;
		edge_cnt_n  = edge_cnt_q;
		phase_n     = phase_q;
		run_n       = run_q;
		pol_n       = pol_q;
		pend_n      = pend_q;
		bit_idx_n   = bit_idx_q;
		fstat_n     = fstat_q;
		emit        = 1'b0;
		emit_bit    = 1'b0;
		wr_en       = 1'b0;
		wr_data     = 1'b0;
		wr_addr     = bit_idx_q[AW-1:0];
		if (accept && (edge_cnt_q < ECW'(MAX_EDGES))) begin
			// the first interval of a frame, between its opening pair of edge items, is ignored
			if (edge_cnt_q >= ECW'(2)) begin
				case (phase_q)
					PH_HUNT: begin
						if (is_short) begin
							if (run_q != RUN_MAX) begin
								run_n = run_q + 4'd1;
							end
						end else if (run_q == SYNC_SHORTS) begin
							phase_n = PH_DECODE;
							pol_n   = 1'b0;
							pend_n  = 1'b0;
						end else begin
							run_n = 4'd0;
						end
					end
					PH_DECODE: begin
						if (pend_q) begin
							pend_n = 1'b0;
							if (is_short) begin
								emit     = 1'b1;
								emit_bit = pol_q;
							end else begin
								fstat_n = ST_VIOLATION;
								phase_n = PH_DONE;
							end
						end else if (is_short) begin
							pend_n = 1'b1;
						end else begin
							pol_n    = ~pol_q;
							emit     = 1'b1;
							emit_bit = ~pol_q;
						end
					end
					default: begin
					end
				endcase
			end
			prev_time_n = capture_time;
			edge_cnt_n  = edge_cnt_q + ECW'(1);
		end

		// hdlc unstuffing of a decoded bit
		if (emit) begin
			if (emit_bit) begin
				if (run_q != RUN_MAX) begin
					run_n = run_q + 4'd1;
				end
				if (bit_idx_q < BW'(DEPTH)) begin
					wr_en     = 1'b1;
					wr_data   = 1'b1;
					bit_idx_n = bit_idx_q + BW'(1);
				end
			end else if (run_q == STUFF_RUN) begin
				run_n = 4'd0;
			end else if (run_q == FLAG_RUN) begin
				phase_n = PH_DONE;
			end else begin
				run_n = 4'd0;
				if (bit_idx_q < BW'(DEPTH)) begin
					wr_en     = 1'b1;
					wr_data   = 1'b0;
					bit_idx_n = bit_idx_q + BW'(1);
				end
			end
		end
	end

	// frame status at close
	always_comb begin
		if (32'(edge_cnt_n) <= 32'(MIN_EDGES)) begin
			close_status = ST_FEW_EDGES;
		end else if (phase_n == PH_HUNT) begin
			close_status = ST_NO_SYNC;
		end else begin
			close_status = fstat_n;
		end
	end

	assign frame_end.valid  = accept && last;
	assign frame_end.status = close_status;
	assign bit_count        = bit_idx_n;

	// frame state registers, cleared at frame close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			edge_cnt_q  <= '0;
			phase_q     <= PH_HUNT;
			run_q       <= '0;
			pol_q       <= 1'b0;
			pend_q      <= 1'b0;
			bit_idx_q   <= '0;
			fstat_q     <= ST_OK;
		end else if (accept && last) begin
			prev_time_q <= '0;
			edge_cnt_q  <= '0;
			phase_q     <= PH_HUNT;
			run_q       <= '0;
			pol_q       <= 1'b0;
			pend_q      <= 1'b0;
			bit_idx_q   <= '0;
			fstat_q     <= ST_OK;
		end else begin
			prev_time_q <= prev_time_n;
			edge_cnt_q  <= edge_cnt_n;
			phase_q     <= phase_n;
			run_q       <= run_n;
			pol_q       <= pol_n;
			pend_q      <= pend_n;
			bit_idx_q   <= bit_idx_n;
			fstat_q     <= fstat_n;
		end
	end

endmodule

// ===== rtl/mhfd_extract.sv =====
// frame-end field extraction: walks the bit store one read a cycle
// depends on mhfd_pkg; drives the read port of the bit store ram
module mhfd_extract import mhfd_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frame_end_t                 frame_end,
	input  logic [$clog2(DEPTH+1)-1:0] bit_count,
	input  field_cfg_t                 fcfg,
	output logic                       rd_en,
	output logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic                       rd_data,
	output logic                       busy,
	output xresult_t                   result
);

	localparam int BW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int IW = (BW > 9) ? BW : 9;

	localparam logic [2:0] X_IDLE  = 3'd0;
	localparam logic [2:0] X_POS   = 3'd1;
	localparam logic [2:0] X_AUX   = 3'd2;
	localparam logic [2:0] X_FLAG  = 3'd3;
	localparam logic [2:0] X_DRAIN = 3'd4;
	localparam logic [2:0] X_DONE  = 3'd5;

	localparam logic [5:0] FIELD_MAX  = 6'd32;
	localparam logic [5:0] FLAG_COUNT = 6'd3;

	logic [2:0]    xs_q;
	logic [5:0]    cnt_q;
	logic [BW-1:0] bcnt_q;
	status_t       st_q;
	logic [31:0]   pos_acc_q;
	logic [31:0]   aux_acc_q;
	logic [2:0]    flag_acc_q;

	logic          tag_vld_s1;
	logic [2:0]    tag_sel_s1;
	logic [4:0]    tag_pos_s1;
	logic          tag_inr_s1;

	logic [5:0]    len_pos;
	logic [5:0]    len_aux;
	logic [5:0]    cur_len;
	logic          issue;
	logic [IW-1:0] idx;
	logic          in_range;
	logic          got_one;

	assign len_pos = (fcfg.pos_length > FIELD_MAX) ? FIELD_MAX : fcfg.pos_length;
	assign len_aux = (fcfg.aux_length > FIELD_MAX) ? FIELD_MAX : fcfg.aux_length;

	// length and bit index of the current read
	always_comb begin
		case (xs_q)
			X_POS:   cur_len = len_pos;
			X_AUX:   cur_len = len_aux;
			X_FLAG:  cur_len = FLAG_COUNT;
			default: cur_len = 6'd0;
		endcase
		case (xs_q)
			X_POS:   idx = IW'(fcfg.pos_offset) + IW'(cnt_q);
			X_AUX:   idx = IW'(fcfg.aux_offset) + IW'(cnt_q);
			default: begin
				case (cnt_q[1:0])
					2'd0:    idx = IW'(fcfg.flag0_index);
					2'd1:    idx = IW'(fcfg.flag1_index);
					default: idx = IW'(fcfg.flag2_index);
				endcase
			end
		endcase
	end

	// bits at or above the received count read as zero, so skip the read
	assign issue    = (xs_q == X_POS || xs_q == X_AUX || xs_q == X_FLAG) && (cnt_q < cur_len);
	assign in_range = idx < IW'(bcnt_q);
	assign rd_en    = issue && in_range;
	assign rd_addr  = idx[AW-1:0];
	assign got_one  = tag_vld_s1 && tag_inr_s1 && rd_data;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xs_q       <= X_IDLE;
			cnt_q      <= '0;
			tag_vld_s1 <= 1'b0;
		end else begin
			tag_vld_s1 <= issue;
			case (xs_q)
				X_IDLE: begin
					cnt_q <= '0;
					if (frame_end.valid) begin
						xs_q <= (frame_end.status == ST_FEW_EDGES) ? X_DONE : X_POS;
					end
				end
				X_POS, X_AUX, X_FLAG: begin
					if (issue) begin
						cnt_q <= cnt_q + 6'd1;
					end else begin
						cnt_q <= '0;
						xs_q  <= (xs_q == X_FLAG) ? X_DRAIN : xs_q + 3'd1;
					end
				end
				X_DRAIN: xs_q <= X_DONE;
				X_DONE:  xs_q <= X_IDLE;
				default: xs_q <= X_IDLE;
			endcase
		end
	end

	// read tag and accumulators
	always_ff @(posedge clk) begin
		tag_sel_s1 <= xs_q;
		tag_pos_s1 <= cnt_q[4:0];
		tag_inr_s1 <= in_range;
		if (xs_q == X_IDLE && frame_end.valid) begin
			bcnt_q     <= bit_count;
			st_q       <= frame_end.status;
			pos_acc_q  <= '0;
			aux_acc_q  <= '0;
			flag_acc_q <= '0;
		end else if (got_one) begin
			case (tag_sel_s1)
				X_POS:   pos_acc_q[tag_pos_s1] <= 1'b1;
				X_AUX:   aux_acc_q[tag_pos_s1] <= 1'b1;
				X_FLAG:  flag_acc_q[tag_pos_s1[1:0]] <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	assign busy                 = (xs_q != X_IDLE);
	assign result.valid         = (xs_q == X_DONE);
	assign result.position      = pos_acc_q;
	assign result.aux_field     = aux_acc_q;
	assign result.flags         = flag_acc_q;
	assign result.bits_received = (st_q == ST_FEW_EDGES) ? 9'd0 : 9'(bcnt_q);
	assign result.status        = st_q;

endmodule

// ===== rtl/manchester_hdlc_edge_frame_decoder_unit.sv =====
// top level of the manchester / hdlc edge frame decoder
// depends on mhfd_pkg, mhfd_ram, mhfd_decoder, mhfd_extract and the macros header
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    capture_time, last
// out      output     out_valid / out_ready  position, aux_field, flag0..2, bits_received, status
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an edge item is decoded as it is taken; its decoded bit goes straight to the bit store
// the last item starts extraction (none if too few edges): up to min(pos_length,32) +
// min(aux_length,32) + 3 reads, one read a cycle on the single read port of the bit store
// the bit store is not cleared after reset; reads are gated by the received bit count
// edges of the next frame are taken while a result waits, its last item only once out is free
`include "manchester_hdlc_edge_frame_decoder_unit_macros.svh"
module manchester_hdlc_edge_frame_decoder_unit import mhfd_pkg::*; #(
	parameter int BIT_STORE_DEPTH = 256,
	parameter int MAX_EDGES       = 512,
	parameter int MIN_EDGES       = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] capture_time,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] position,
	output logic [31:0] aux_field,
	output logic        flag0,
	output logic        flag1,
	output logic        flag2,
	output logic [8:0]  bits_received,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(BIT_STORE_DEPTH);
	localparam int BW = $clog2(BIT_STORE_DEPTH + 1);

	localparam logic [3:0] REG_SHORT_INTERVAL = 4'd0;
	localparam logic [3:0] REG_POS_OFFSET     = 4'd1;
	localparam logic [3:0] REG_POS_LENGTH     = 4'd2;
	localparam logic [3:0] REG_AUX_OFFSET     = 4'd3;
	localparam logic [3:0] REG_AUX_LENGTH     = 4'd4;
	localparam logic [3:0] REG_FLAG0_INDEX    = 4'd5;
	localparam logic [3:0] REG_FLAG1_INDEX    = 4'd6;
	localparam logic [3:0] REG_FLAG2_INDEX    = 4'd7;

	logic [15:0] short_interval_q;
	field_cfg_t  fcfg_q;

	logic          in_accept;
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic          ram_wr_data;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic          ram_rd_data;
	frame_end_t    fe;
	logic [BW-1:0] bit_count;
	logic          x_busy;
	xresult_t      x_res;
	logic          out_valid_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_interval_q   <= 16'd15;
			fcfg_q.pos_offset  <= 8'd64;
			fcfg_q.pos_length  <= 6'd15;
			fcfg_q.aux_offset  <= 8'd0;
			fcfg_q.aux_length  <= 6'd0;
			fcfg_q.flag0_index <= 8'd57;
			fcfg_q.flag1_index <= 8'd58;
			fcfg_q.flag2_index <= 8'd59;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SHORT_INTERVAL: short_interval_q   <= cfg_data;
				REG_POS_OFFSET:     fcfg_q.pos_offset  <= cfg_data[7:0];
				REG_POS_LENGTH:     fcfg_q.pos_length  <= cfg_data[5:0];
				REG_AUX_OFFSET:     fcfg_q.aux_offset  <= cfg_data[7:0];
				REG_AUX_LENGTH:     fcfg_q.aux_length  <= cfg_data[5:0];
				REG_FLAG0_INDEX:    fcfg_q.flag0_index <= cfg_data[7:0];
				REG_FLAG1_INDEX:    fcfg_q.flag1_index <= cfg_data[7:0];
				REG_FLAG2_INDEX:    fcfg_q.flag2_index <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// input interlock: no edges while the store is read, no close while out is full
	assign in_ready  = !x_busy && !(out_valid_q && last);
	assign in_accept = in_valid && in_ready;

	mhfd_decoder #(
		.DEPTH     (BIT_STORE_DEPTH),
		.MAX_EDGES (MAX_EDGES),
		.MIN_EDGES (MIN_EDGES)
	) u_decoder (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_accept),
		.capture_time   (capture_time),
		.last           (last),
		.short_interval (short_interval_q),
		.wr_en          (ram_wr_en),
		.wr_addr        (ram_wr_addr),
		.wr_data        (ram_wr_data),
		.frame_end      (fe),
		.bit_count      (bit_count)
	);

	mhfd_ram #(
		.WIDTH (1),
		.DEPTH (BIT_STORE_DEPTH)
	) u_bit_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	mhfd_extract #(
		.DEPTH (BIT_STORE_DEPTH)
	) u_extract (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_end (fe),
		.bit_count (bit_count),
		.fcfg      (fcfg_q),
		.rd_en     (ram_rd_en),
		.rd_addr   (ram_rd_addr),
		.rd_data   (ram_rd_data),
		.busy      (x_busy),
		.result    (x_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (x_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (x_res.valid) begin
			position      <= x_res.position;
			aux_field     <= x_res.aux_field;
			flag0         <= x_res.flags[0];
			flag1         <= x_res.flags[1];
			flag2         <= x_res.flags[2];
			bits_received <= x_res.bits_received;
			status        <= x_res.status;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`MHFD_ASSERT(a_no_write_during_read, clk, arst_n, !(ram_wr_en && x_busy), "bit store written during extraction")
	`MHFD_ASSERT(a_close_when_free, clk, arst_n, fe.valid |-> (!x_busy && !out_valid_q), "frame closed while extractor or output busy")
	`MHFD_ASSERT_NEXT(a_result_registered, clk, arst_n, x_res.valid, out_valid_q, "finished result not presented")

endmodule

// ===== sim/tb_manchester_hdlc_edge_frame_decoder_unit.sv =====
`timescale 1ns / 100ps
// testbench for the manchester / hdlc edge frame decoder unit: directed and random frames
// depends on mhfd_pkg and manchester_hdlc_edge_frame_decoder_unit; self-checking, no files read
module tb_manchester_hdlc_edge_frame_decoder_unit;
	import mhfd_pkg::*;

	// register indexes
	localparam logic [3:0] REG_SHORT_INTERVAL = 4'd0;
	localparam logic [3:0] REG_POS_OFFSET     = 4'd1;
	localparam logic [3:0] REG_POS_LENGTH     = 4'd2;
	localparam logic [3:0] REG_AUX_OFFSET     = 4'd3;
	localparam logic [3:0] REG_AUX_LENGTH     = 4'd4;
	localparam logic [3:0] REG_FLAG0_INDEX    = 4'd5;
	localparam logic [3:0] REG_FLAG1_INDEX    = 4'd6;
	localparam logic [3:0] REG_FLAG2_INDEX    = 4'd7;
	localparam logic [3:0] REG_SPARE          = 4'd15;

	localparam int STORE_DEPTH    = 256;
	localparam int EDGE_LIMIT     = 512;
	localparam int FEW_EDGES      = 80;
	localparam int SYNC_SHORTS    = 10;
	localparam int STUFF_RUN      = 5;
	localparam int FLAG_RUN       = 6;
	localparam int RUN_SAT        = 15;
	localparam int EXTRACT_CYCLES = 100;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int RANDOM_FRAMES  = 40;

	typedef enum logic [1:0] {SEEK_SYNC, DECODING, CLOSED} decode_phase_e;
	typedef enum int {FR_CLEAN, FR_NO_FLAG, FR_HALF_BIT, FR_VIOLATION, FR_BAD_SYNC, FR_NOISE}
		frame_kind_e;

	typedef struct {
		logic [31:0] position;
		logic [31:0] aux_field;
		logic [2:0]  flags;
		logic [8:0]  bits_received;
		status_t     status;
	} frame_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [15:0] capture_time  = '0;
	logic        last          = 1'b0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [31:0] position;
	logic [31:0] aux_field;
	logic        flag0;
	logic        flag1;
	logic        flag2;
	logic [8:0]  bits_received;
	logic [1:0]  status;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;

	manchester_hdlc_edge_frame_decoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .capture_time(capture_time), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .position(position),
		.aux_field(aux_field), .flag0(flag0), .flag1(flag1), .flag2(flag2),
		.bits_received(bits_received), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register copy
	logic [15:0] short_thr;
	field_cfg_t  fields;

	// decoder state of the current frame
	logic [15:0]   prev_time;
	int            edge_cnt;
	decode_phase_e dec_phase;
	logic [3:0]    run_len;
	logic          pol;
	logic          half_pending;
	int            nbits;
	logic          store_bits [STORE_DEPTH];
	status_t       frame_err;

	frame_result_t expected_frames [$];
	int            mismatches   = 0;
	int            items_sent   = 0;
	int            results_seen = 0;
	bit            steady_flow  = 1'b0;

	// frame generator state
	logic [15:0] frame_deltas [$];
	logic        gen_pol;
	int          gen_run;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("tb_manchester_hdlc_edge_frame_decoder_unit: done, errors");
		$finish;
	end

	task automatic clear_frame_state();
		prev_time    = '0;
		edge_cnt     = 0;
		dec_phase    = SEEK_SYNC;
		run_len      = '0;
		pol          = 1'b0;
		half_pending = 1'b0;
		nbits        = 0;
		frame_err    = ST_OK;
	endtask

	// bits never received read as zero
	function automatic logic stored_bit(int idx);
		return (idx < nbits && idx < STORE_DEPTH) ? store_bits[idx] : 1'b0;
	endfunction

	function automatic logic [31:0] gather_field(int off, int len);
		logic [31:0] v;
		v = '0;
		if (len > 32) len = 32;
		for (int i = 0; i < len; i++) v[i] = stored_bit(off + i);
		return v;
	endfunction

	// hdlc unstuffing of one decoded bit
	task automatic take_decoded_bit(logic b);
		if (b) begin
			if (run_len < RUN_SAT) run_len++;
			if (nbits < STORE_DEPTH) begin
				store_bits[nbits] = 1'b1;
				nbits++;
			end
		end else if (run_len == STUFF_RUN) begin
			run_len = '0;
		end else if (run_len == FLAG_RUN) begin
			dec_phase = CLOSED;
		end else begin
			run_len = '0;
			if (nbits < STORE_DEPTH) begin
				store_bits[nbits] = 1'b0;
				nbits++;
			end
		end
	endtask

	// expected behavior for one accepted edge item
	task automatic decode_edge(logic [15:0] t, logic l);
		logic [15:0]   d;
		logic          is_short;
		frame_result_t r;
		if (edge_cnt < EDGE_LIMIT) begin
			if (edge_cnt >= 2) begin
				d = t - prev_time;
				is_short = (d < short_thr);
				case (dec_phase)
					SEEK_SYNC: begin
						if (is_short) begin
							if (run_len < RUN_SAT) run_len++;
						end else if (run_len == SYNC_SHORTS) begin
							dec_phase    = DECODING;
							pol          = 1'b0;
							half_pending = 1'b0;
						end else begin
							run_len = '0;
						end
					end
					DECODING: begin
						if (half_pending) begin
							half_pending = 1'b0;
							if (is_short) begin
								take_decoded_bit(pol);
							end else begin
								frame_err = ST_VIOLATION;
								dec_phase = CLOSED;
							end
						end else if (is_short) begin
							half_pending = 1'b1;
						end else begin
							pol = ~pol;
							take_decoded_bit(pol);
						end
					end
					default: ;
				endcase
			end
			prev_time = t;
			edge_cnt++;
		end
		if (l) begin
			if (edge_cnt <= FEW_EDGES) r.status = ST_FEW_EDGES;
			else if (dec_phase == SEEK_SYNC) r.status = ST_NO_SYNC;
			else r.status = frame_err;
			if (r.status == ST_FEW_EDGES) begin
				r.position      = '0;
				r.aux_field     = '0;
				r.flags         = '0;
				r.bits_received = '0;
			end else begin
				r.position      = gather_field(fields.pos_offset, fields.pos_length);
				r.aux_field     = gather_field(fields.aux_offset, fields.aux_length);
				r.flags         = {stored_bit(fields.flag2_index), stored_bit(fields.flag1_index),
					stored_bit(fields.flag0_index)};
				r.bits_received = 9'(nbits);
			end
			expected_frames.push_back(r);
			clear_frame_state();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch on %0s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// compare every accepted result item with the oldest expectation
	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_frames.size() == 0) begin
				report_mismatch("result with none expected", position, '0);
			end else begin
				want = expected_frames.pop_front();
				if (position !== want.position)
					report_mismatch("position", position, want.position);
				if (aux_field !== want.aux_field)
					report_mismatch("aux_field", aux_field, want.aux_field);
				if (flag0 !== want.flags[0]) report_mismatch("flag0", flag0, want.flags[0]);
				if (flag1 !== want.flags[1]) report_mismatch("flag1", flag1, want.flags[1]);
				if (flag2 !== want.flags[2]) report_mismatch("flag2", flag2, want.flags[2]);
				if (bits_received !== want.bits_received)
					report_mismatch("bits_received", bits_received, want.bits_received);
				if (status !== want.status) report_mismatch("status", status, want.status);
			end
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (steady_flow) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side stalls
	initial begin : result_sink
		int stall;
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// send one edge item; valid stays high afterwards
	task automatic send_edge_item(logic [15:0] t, logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		capture_time <= t;
		last         <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_edge(t, l);
		items_sent++;
	endtask

	// hold off until every expected result is out and extraction has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (EXTRACT_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SHORT_INTERVAL: short_thr          = val;
			REG_POS_OFFSET:     fields.pos_offset  = val[7:0];
			REG_POS_LENGTH:     fields.pos_length  = val[5:0];
			REG_AUX_OFFSET:     fields.aux_offset  = val[7:0];
			REG_AUX_LENGTH:     fields.aux_length  = val[5:0];
			REG_FLAG0_INDEX:    fields.flag0_index = val[7:0];
			REG_FLAG1_INDEX:    fields.flag1_index = val[7:0];
			REG_FLAG2_INDEX:    fields.flag2_index = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(logic [15:0] thr, logic [15:0] po, logic [15:0] pl,
		logic [15:0] ao, logic [15:0] al, logic [15:0] f0, logic [15:0] f1, logic [15:0] f2);
		wait_idle();
		write_reg(REG_SHORT_INTERVAL, thr);
		write_reg(REG_POS_OFFSET, po);
		write_reg(REG_POS_LENGTH, pl);
		write_reg(REG_AUX_OFFSET, ao);
		write_reg(REG_AUX_LENGTH, al);
		write_reg(REG_FLAG0_INDEX, f0);
		write_reg(REG_FLAG1_INDEX, f1);
		write_reg(REG_FLAG2_INDEX, f2);
	endtask

	// interval values on either side of the threshold, edges included
	function automatic logic [15:0] short_delta();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return short_thr - 16'd1;
		if (r == 1) return 16'd0;
		return 16'($urandom_range(0, short_thr - 1));
	endfunction

	function automatic logic [15:0] long_delta();
		if ($urandom_range(0, 9) == 0) return short_thr;
		return 16'($urandom_range(short_thr, 65535));
	endfunction

	// manchester line coding of one bit
	task automatic line_bit(logic b);
		if (b == gen_pol) begin
			frame_deltas.push_back(short_delta());
			frame_deltas.push_back(short_delta());
		end else begin
			frame_deltas.push_back(long_delta());
			gen_pol = b;
		end
	endtask

	// payload bit with a stuffed zero after five ones
	task automatic data_bit(logic b);
		if (gen_run == STUFF_RUN) begin
			line_bit(1'b0);
			gen_run = 0;
		end
		line_bit(b);
		if (b) gen_run = (gen_run < RUN_SAT) ? gen_run + 1 : RUN_SAT;
		else gen_run = 0;
	endtask

	task automatic build_frame(int nbits_req, int ones_tenths, frame_kind_e kind);
		int viol_at;
		int sync_n;
		frame_deltas.delete();
		gen_pol = 1'b0;
		gen_run = SYNC_SHORTS;
		viol_at = $urandom_range(0, nbits_req - 1);
		sync_n  = SYNC_SHORTS;
		if (kind == FR_BAD_SYNC)
			sync_n = $urandom_range(0, 1) ? SYNC_SHORTS - 1 : SYNC_SHORTS + 1;
		// ignored first interval, then a little hunt noise closed by a long interval
		frame_deltas.push_back(16'($urandom));
		repeat ($urandom_range(0, 4))
			frame_deltas.push_back($urandom_range(0, 1) ? short_delta() : long_delta());
		frame_deltas.push_back(long_delta());
		if (kind == FR_NOISE) begin
			repeat (nbits_req) frame_deltas.push_back(16'($urandom));
			return;
		end
		// preamble and sync
		repeat (sync_n) frame_deltas.push_back(short_delta());
		frame_deltas.push_back(long_delta());
		for (int i = 0; i < nbits_req; i++) begin
			if (kind == FR_VIOLATION && i == viol_at) begin
				frame_deltas.push_back(short_delta());
				frame_deltas.push_back(long_delta());
			end
			data_bit($urandom_range(0, 9) < ones_tenths);
		end
		case (kind)
			FR_CLEAN, FR_VIOLATION, FR_BAD_SYNC: begin
				// closing flag: a zero, six ones, the terminating zero, then junk
				data_bit(1'b0);
				repeat (FLAG_RUN) line_bit(1'b1);
				line_bit(1'b0);
				repeat ($urandom_range(0, 3)) frame_deltas.push_back(16'($urandom));
			end
			FR_HALF_BIT: frame_deltas.push_back(short_delta());
			default: ;
		endcase
	endtask

	task automatic play_frame();
		logic [15:0] t;
		t = 16'($urandom);
		send_edge_item(t, frame_deltas.size() == 0);
		foreach (frame_deltas[i]) begin
			t = t + frame_deltas[i];
			send_edge_item(t, i == frame_deltas.size() - 1);
		end
	endtask

	task automatic send_short_frame(int n);
		frame_deltas.delete();
		repeat (n - 1) frame_deltas.push_back(16'($urandom));
		play_frame();
	endtask

	// clean frames under the reset register values
	task automatic test_reset_defaults();
		steady_flow = 1'b1;
		build_frame(90, 6, FR_CLEAN);
		play_frame();
		steady_flow = 1'b0;
		build_frame(100, 9, FR_CLEAN);
		play_frame();
		build_frame(80, 1, FR_CLEAN);
		play_frame();
	endtask

	// too few edges around the limit, missing sync, manchester violation
	task automatic test_frame_errors();
		send_short_frame(1);
		send_short_frame(FEW_EDGES);
		send_short_frame(FEW_EDGES + 1);
		build_frame(90, 5, FR_BAD_SYNC);
		play_frame();
		build_frame(90, 5, FR_BAD_SYNC);
		play_frame();
		build_frame(100, 5, FR_NOISE);
		play_frame();
		build_frame(90, 6, FR_VIOLATION);
		play_frame();
		build_frame(90, 6, FR_VIOLATION);
		play_frame();
	endtask

	// frame ends with no flag, with a lone half bit, with an early flag
	task automatic test_frame_ends();
		build_frame(90, 6, FR_NO_FLAG);
		play_frame();
		build_frame(90, 6, FR_HALF_BIT);
		play_frame();
		build_frame(60, 2, FR_CLEAN);
		play_frame();
	endtask

	// bit store overflow, and edges past the per-frame limit
	task automatic test_overflow();
		build_frame(300, 5, FR_CLEAN);
		play_frame();
		build_frame(560, 5, FR_NO_FLAG);
		play_frame();
	endtask

	// register extremes, lengths above 32, unused index, junk upper data bits
	task automatic test_config_extremes();
		write_all(16'd1, 16'd0, 16'd32, 16'd255, 16'd32, 16'd0, 16'd255, 16'd1);
		build_frame(100, 5, FR_CLEAN);
		play_frame();
		build_frame(120, 8, FR_CLEAN);
		play_frame();
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd32, 16'd255, 16'd0, 16'd128);
		write_reg(REG_SPARE, 16'($urandom));
		build_frame(90, 5, FR_CLEAN);
		play_frame();
		build_frame(90, 5, FR_VIOLATION);
		play_frame();
		write_all(16'd2, 16'hA50A, 16'hFFE8, 16'h5A28, 16'h001F, 16'hC308, 16'h3C09, 16'h000A);
		build_frame(90, 5, FR_CLEAN);
		play_frame();
		build_frame(110, 7, FR_CLEAN);
		play_frame();
	endtask

	// random frames, mostly well formed, new register setting every few frames
	task automatic test_random_frames();
		int          first_item;
		int          frames;
		int          r;
		int          nb;
		logic [15:0] thr;
		frame_kind_e kind;
		first_item = items_sent;
		frames     = 0;
		while (items_sent - first_item < RANDOM_ITEMS || frames < RANDOM_FRAMES) begin
			if (frames % 5 == 0) begin
				case ($urandom_range(0, 9))
					0:       thr = 16'd1;
					1:       thr = 16'hFFFF;
					2:       thr = 16'($urandom_range(1, 65535));
					default: thr = 16'($urandom_range(2, 60));
				endcase
				write_all(thr,
					{8'($urandom), 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
						: $urandom_range(0, 110))},
					{10'($urandom), 6'($urandom_range(0, 7) == 0 ? $urandom_range(33, 63)
						: $urandom_range(0, 32))},
					{8'($urandom), 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
						: $urandom_range(0, 110))},
					{10'($urandom), 6'($urandom_range(0, 7) == 0 ? $urandom_range(33, 63)
						: $urandom_range(0, 32))},
					{8'($urandom), 8'($urandom_range(0, 110))},
					{8'($urandom), 8'($urandom_range(0, 255))},
					{8'($urandom), 8'($urandom_range(0, 110))});
				steady_flow = ($urandom_range(0, 4) == 0);
			end
			if ($urandom_range(0, 99) < 8) begin
				send_short_frame($urandom_range(1, FEW_EDGES + 5));
			end else begin
				nb = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300)
					: $urandom_range(45, 130);
				r  = $urandom_range(0, 99);
				if (r < 70) kind = FR_CLEAN;
				else if (r < 76) kind = FR_NO_FLAG;
				else if (r < 82) kind = FR_HALF_BIT;
				else if (r < 88) kind = FR_VIOLATION;
				else if (r < 94) kind = FR_BAD_SYNC;
				else kind = FR_NOISE;
				build_frame(nb, $urandom_range(2, 9), kind);
				play_frame();
			end
			frames++;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		short_thr = 16'd15;
		fields = '{pos_offset: 8'd64, pos_length: 6'd15, aux_offset: 8'd0, aux_length: 6'd0,
			flag0_index: 8'd57, flag1_index: 8'd58, flag2_index: 8'd59};
		clear_frame_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_frame_errors();
		test_frame_ends();
		test_overflow();
		test_config_extremes();
		test_random_frames();
		wait_idle();
		if (mismatches == 0) begin
			$display("tb_manchester_hdlc_edge_frame_decoder_unit: done, clean");
		end else begin
			$display("tb_manchester_hdlc_edge_frame_decoder_unit: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mhfd_pkg.sv
rtl/mhfd_ram.sv
rtl/mhfd_decoder.sv
rtl/mhfd_extract.sv
rtl/manchester_hdlc_edge_frame_decoder_unit.sv
sim/tb_manchester_hdlc_edge_frame_decoder_unit.sv
